// File: rtl/waef_pkg.sv
// ----------------------------------------------------------------------------
// waef_pkg
// Shared types and constants of the weekly alarm earliest finder.
// ----------------------------------------------------------------------------
package waef_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
	localparam logic [19:0] SEC_PER_WEEK = 20'd604800;

	localparam int DIST_W = 22;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic [6:0]  day_mask;
		logic        count_mode;
		logic [16:0] second_mark;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  alarm_index;
		logic [19:0] seconds_until;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [6:0]  day_mask;
		logic        count_mode;
		logic [16:0] second_mark;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_t;

	// seconds at the start of day offset d
	function automatic logic [19:0] day_offset_sec(input logic [2:0] d);
		logic [19:0] r;
		r = 20'(d) * 20'(SEC_PER_DAY);
		return r;
	endfunction

endpackage

// File: rtl/waef_req_if.sv
// ----------------------------------------------------------------------------
// waef_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface waef_req_if;
	import waef_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/waef_rsp_if.sv
// ----------------------------------------------------------------------------
// waef_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface waef_rsp_if;
	import waef_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/weekly_alarm_earliest_finder.sv
// ----------------------------------------------------------------------------
// weekly_alarm_earliest_finder
// Write item: result valid the cycle after accept; writes can follow every cycle while
// the response is not stalled. Query item: the shared distance unit checks one slot per
// cycle, the slots up to and including the first invalid one, or all of them (1 to 16).
// The result is registered as the scan ends; ready is low during a scan.
// Reset clears all slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module weekly_alarm_earliest_finder (
	input  logic            clk,
	input  logic            arst_n,
	waef_req_if.sink        req,
	waef_rsp_if.source      rsp
);
	import waef_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [16:0]      now_q, now_d;
	logic [2:0]       today_q, today_d;
	logic             best_found_q, best_found_d;
	logic [IDX_W-1:0] best_idx_q, best_idx_d;
	logic [19:0]      best_dist_q, best_dist_d;
	logic             rsp_valid_q, rsp_valid_d;
	rsp_t             rsp_q, rsp_d;

	wr_t              wr;
	entry_t           entry;
	logic [19:0]      distance;
	logic             accept;
	logic             out_free;
	logic             consider;

	waef_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (idx_q),
		.rd_data (entry)
	);

	waef_dist u_dist (
		.day_mask    (entry.day_mask),
		.second_mark (entry.second_mark),
		.today       (today_q),
		.now         (now_q),
		.distance    (distance)
	);

	assign out_free    = !rsp_valid_q || rsp.ready;
	assign req.ready   = (state_q == ST_IDLE) && out_free;
	assign accept      = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		now_d        = now_q;
		today_d      = today_q;
		best_found_d = best_found_q;
		best_idx_d   = best_idx_q;
		best_dist_d  = best_dist_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		rsp_d        = rsp_q;
		consider     = 1'b0;

		wr.en        = 1'b0;
		wr.addr      = req.payload.entry_index[IDX_W-1:0];
		wr.data.valid       = req.payload.entry_valid;
		wr.data.day_mask    = req.payload.day_mask;
		wr.data.count_mode  = req.payload.count_mode;
		wr.data.second_mark = req.payload.second_mark;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.payload.operation == OP_WRITE) begin
						wr.en       = 32'(req.payload.entry_index) < TABLE_DEPTH;
						rsp_valid_d = 1'b1;
						rsp_d       = '0;
					end else begin
						now_d = 17'(req.payload.hour) * 17'(SEC_PER_HOUR)
						      + 17'(req.payload.minute) * 17'(SEC_PER_MIN)
						      + 17'(req.payload.second);
						today_d      = (req.payload.weekday == 3'd7) ? 3'd0
						             : req.payload.weekday;
						idx_d        = '0;
						best_found_d = 1'b0;
						best_idx_d   = '0;
						best_dist_d  = '0;
						state_d      = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!entry.valid) begin
					state_d = ST_IDLE;
				end else begin
					consider = !entry.count_mode && (entry.day_mask != 7'd0);
					if (consider && (!best_found_q || distance < best_dist_q)) begin
						best_found_d = 1'b1;
						best_idx_d   = idx_q;
						best_dist_d  = distance;
					end
					if (32'(idx_q) == TABLE_DEPTH - 1) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				if (state_d == ST_IDLE) begin
					rsp_valid_d         = 1'b1;
					rsp_d.found         = best_found_d;
					rsp_d.alarm_index   = 4'(best_idx_d);
					rsp_d.seconds_until = best_dist_d;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rsp_valid_q  <= 1'b0;
			idx_q        <= '0;
			best_found_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			rsp_valid_q  <= rsp_valid_d;
			idx_q        <= idx_d;
			best_found_q <= best_found_d;
		end
	end

	always_ff @(posedge clk) begin
		now_q       <= now_d;
		today_q     <= today_d;
		best_idx_q  <= best_idx_d;
		best_dist_q <= best_dist_d;
		rsp_q       <= rsp_d;
	end

endmodule

// File: rtl/waef_table.sv
// ----------------------------------------------------------------------------
// waef_table
// Alarm entry storage: one write port, one read port at the scan index.
// Valid bits clear on reset; the other fields hold whatever was written.
// ----------------------------------------------------------------------------
module waef_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  waef_pkg::wr_t          wr,
	input  logic [waef_pkg::IDX_W-1:0] rd_addr,
	output waef_pkg::entry_t       rd_data
);
	import waef_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [6:0]             mask_q [TABLE_DEPTH];
	logic                   count_q [TABLE_DEPTH];
	logic [16:0]            mark_q [TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= wr.data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mask_q[wr.addr]  <= wr.data.day_mask;
			count_q[wr.addr] <= wr.data.count_mode;
			mark_q[wr.addr]  <= wr.data.second_mark;
		end
	end

	always_comb begin
		rd_data.valid       = valid_q[rd_addr];
		rd_data.day_mask    = mask_q[rd_addr];
		rd_data.count_mode  = count_q[rd_addr];
		rd_data.second_mark = mark_q[rd_addr];
	end

endmodule

// File: rtl/waef_dist.sv
// ----------------------------------------------------------------------------
// waef_dist
// Shared distance unit: seconds from now to an entry's next firing,
// clamped to one week.
// ----------------------------------------------------------------------------
module waef_dist (
	input  logic [6:0]  day_mask,
	input  logic [16:0] second_mark,
	input  logic [2:0]  today,
	input  logic [16:0] now,
	output logic [19:0] distance
);
	import waef_pkg::*;

	logic [7:0]        hit;
	logic [3:0]        day_sum;
	logic [2:0]        day_idx;
	logic [2:0]        sel_d;
	logic              any_hit;
	logic [DIST_W-1:0] raw;

	always_comb begin
		for (int d = 0; d < 8; d++) begin
			day_sum = 4'(today) + 4'(d);
			day_idx = (day_sum >= 4'd7) ? 3'(day_sum - 4'd7) : day_sum[2:0];
			hit[d]  = day_mask[day_idx];
		end
		hit[0] = hit[0] && (second_mark >= now);

		any_hit = 1'b0;
		sel_d   = '0;
		for (int d = 7; d >= 0; d--) begin
			if (hit[d]) begin
				any_hit = 1'b1;
				sel_d   = 3'(d);
			end
		end

		raw = DIST_W'(day_offset_sec(sel_d)) + DIST_W'(second_mark) - DIST_W'(now);

		if (!any_hit || raw[DIST_W-1]) begin
			distance = '0;
		end else if (raw > DIST_W'(SEC_PER_WEEK)) begin
			distance = SEC_PER_WEEK;
		end else begin
			distance = raw[19:0];
		end
	end

endmodule

// File: tb/tb_weekly_alarm_earliest_finder.sv
// ----------------------------------------------------------------------------
// tb_weekly_alarm_earliest_finder
// Writes alarm slots and queries the earliest alarm through the request
// channel. A local copy of the slot table predicts every result, which is
// compared in order against the response channel. Directed cases come first:
// skipped slots, the end marker, ties, marks at or past now, weekday seven,
// out-of-range times and the clamp at both ends of the week. Random traffic
// and a long output stall follow.
// ----------------------------------------------------------------------------
module tb_weekly_alarm_earliest_finder;
	timeunit 1ns;
	timeprecision 1ps;

	import waef_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int SUN = 0;
	localparam int WED = 3;
	localparam int SAT = 6;

	logic clk = 1'b0;
	logic arst_n;

	waef_req_if req();
	waef_rsp_if rsp();

	weekly_alarm_earliest_finder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	bit          slot_used   [TABLE_DEPTH];
	logic [6:0]  slot_days   [TABLE_DEPTH];
	bit          slot_counts [TABLE_DEPTH];
	logic [16:0] slot_mark   [TABLE_DEPTH];

	rsp_t expected_alarms[$];

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_found = 0;
	int n_week = 0;
	int send_gap_pct = 0;
	int rsp_idle_pct = 0;
	int stall_left = 0;

	function automatic int secs_to_alarm(input logic [6:0] days, input int mark,
			input int today, input int now);
		int distance;
		int wd;
		bit hit;
		distance = 0;
		hit = 1'b0;
		for (int d = 0; d < 8; d++) begin
			wd = (today + d) % 7;
			if (!hit && days[wd] && (d > 0 || mark >= now)) begin
				hit = 1'b1;
				distance = d * int'(SEC_PER_DAY) + mark - now;
			end
		end
		if (distance < 0)
			distance = 0;
		if (distance > int'(SEC_PER_WEEK))
			distance = int'(SEC_PER_WEEK);
		return distance;
	endfunction

	function automatic rsp_t alarm_table_step(input req_t item);
		rsp_t res;
		int today;
		int now;
		int distance;
		int best;
		bit scanning;
		res = '0;
		best = 0;
		if (item.operation == OP_WRITE) begin
			n_writes++;
			slot_used[item.entry_index] = item.entry_valid;
			slot_days[item.entry_index] = item.day_mask;
			slot_counts[item.entry_index] = item.count_mode;
			slot_mark[item.entry_index] = item.second_mark;
		end else begin
			n_queries++;
			today = int'(item.weekday) % 7;
			now = int'(item.hour) * int'(SEC_PER_HOUR) + int'(item.minute) * int'(SEC_PER_MIN)
				+ int'(item.second);
			scanning = 1'b1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (scanning && !slot_used[i])
					scanning = 1'b0;
				if (scanning && !slot_counts[i] && slot_days[i] != '0) begin
					distance = secs_to_alarm(slot_days[i], int'(slot_mark[i]), today, now);
					if (!res.found || distance < best) begin
						res.found = 1'b1;
						res.alarm_index = 4'(i);
						res.seconds_until = 20'(distance);
						best = distance;
					end
				end
			end
			if (res.found)
				n_found++;
			if (res.found && best == int'(SEC_PER_WEEK))
				n_week++;
		end
		return res;
	endfunction

	function automatic req_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic req_t random_entry(input int idx);
		req_t r;
		r = random_item();
		r.operation = OP_WRITE;
		r.entry_index = 4'(idx);
		r.entry_valid = 1'b1;
		case ($urandom_range(9))
			0: r.day_mask = '0;
			1, 2, 3: r.day_mask = 7'(1 << $urandom_range(6));
			default: r.day_mask = 7'($urandom);
		endcase
		r.count_mode = ($urandom_range(7) == 0);
		case ($urandom_range(9))
			0: r.second_mark = 17'($urandom);
			1, 2: r.second_mark = 17'($urandom_range(23) * 3600);
			default: r.second_mark = 17'($urandom_range(86399));
		endcase
		return r;
	endfunction

	function automatic req_t random_query();
		req_t r;
		r = random_item();
		r.operation = OP_QUERY;
		r.weekday = 3'($urandom_range(7));
		if ($urandom_range(9) != 0) begin
			r.hour = 5'($urandom_range(23));
			r.minute = 6'($urandom_range(59));
			r.second = 6'($urandom_range(59));
		end
		if ($urandom_range(3) == 0) begin
			r.minute = '0;
			r.second = '0;
		end
		return r;
	endfunction

	function automatic req_t entry_write(input int idx, input bit used, input logic [6:0] days,
			input bit counts, input logic [16:0] mark);
		req_t r;
		r = '0;
		r.operation = OP_WRITE;
		r.entry_index = 4'(idx);
		r.entry_valid = used;
		r.day_mask = days;
		r.count_mode = counts;
		r.second_mark = mark;
		return r;
	endfunction

	function automatic req_t clock_query(input int wd, input int hh, input int mm, input int ss);
		req_t r;
		r = '0;
		r.operation = OP_QUERY;
		r.weekday = 3'(wd);
		r.hour = 5'(hh);
		r.minute = 6'(mm);
		r.second = 6'(ss);
		return r;
	endfunction

	task automatic send_item(input req_t item);
		while ($urandom_range(99) < send_gap_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= item;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		expected_alarms.push_back(alarm_table_step(item));
		items_sent++;
		@(negedge clk);
	endtask

	// receiver: decide at the rising edge, drive at the falling edge
	initial begin
		bit take;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				take = 1'b0;
				stall_left--;
			end else begin
				take = ($urandom_range(99) >= rsp_idle_pct);
			end
			@(negedge clk);
			rsp.ready <= take;
		end
	end

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.payload;
			if (expected_alarms.size() == 0) begin
				$error("unexpected result: found %0d alarm_index %0d seconds_until %0d",
					got.found, got.alarm_index, got.seconds_until);
				errors++;
			end else begin
				want = expected_alarms.pop_front();
				if (got.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, got.found);
					errors++;
				end
				if (got.alarm_index !== want.alarm_index) begin
					$error("alarm_index: expected %0d, got %0d", want.alarm_index,
						got.alarm_index);
					errors++;
				end
				if (got.seconds_until !== want.seconds_until) begin
					$error("seconds_until: expected %0d, got %0d", want.seconds_until,
						got.seconds_until);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_alarms.size());
			$display("tb_weekly_alarm_earliest_finder failed");
			$finish;
		end
	end

	task automatic test_empty_table();
		send_item(clock_query(SUN, 0, 0, 0));
		send_item(entry_write(0, 1'b0, 7'h7f, 1'b0, 17'd0));
		send_item(clock_query(SAT, 23, 59, 59));
	endtask

	task automatic test_schedule_rules();
		send_item(entry_write(0, 1'b1, 7'b0001000, 1'b0, 17'd36000));
		send_item(entry_write(1, 1'b1, 7'b0000000, 1'b0, 17'd100));
		send_item(entry_write(2, 1'b1, 7'b1111111, 1'b1, 17'd0));
		send_item(entry_write(3, 1'b1, 7'b1111111, 1'b0, 17'd43200));
		send_item(entry_write(4, 1'b1, 7'b0001000, 1'b0, 17'd36000));
		send_item(entry_write(5, 1'b1, 7'b1000000, 1'b0, 17'h1ffff));
		send_item(entry_write(6, 1'b0, 7'b1111111, 1'b1, 17'h1ffff));
		send_item(entry_write(15, 1'b1, 7'b1111111, 1'b0, 17'd0));
		// mark equal to now fires today; slot 4 ties and loses
		send_item(clock_query(WED, 10, 0, 0));
		send_item(clock_query(WED, 10, 0, 1));
		send_item(clock_query(7, 31, 63, 63));
		send_item(clock_query(SAT, 0, 0, 0));
	endtask

	task automatic test_week_clamp();
		send_item(entry_write(1, 1'b0, 7'b0000000, 1'b0, 17'd0));
		send_item(entry_write(0, 1'b1, 7'b1000000, 1'b0, 17'h1ffff));
		send_item(clock_query(SUN, 0, 0, 0));
		send_item(entry_write(0, 1'b1, 7'b0000010, 1'b0, 17'd0));
		send_item(clock_query(SUN, 31, 63, 63));
	endtask

	task automatic test_random_traffic(input int gap_pct, input int idle_pct, input int count);
		int stop_at;
		int fill;
		req_t e;
		send_gap_pct = gap_pct;
		rsp_idle_pct = idle_pct;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(9))
				0: send_item(random_item());
				1, 2, 3: begin
					repeat ($urandom_range(1, 3)) begin
						e = random_entry($urandom_range(TABLE_DEPTH - 1));
						e.entry_valid = ($urandom_range(4) != 0);
						send_item(e);
					end
					send_item(random_query());
				end
				default: begin
					fill = $urandom_range(1, TABLE_DEPTH);
					for (int i = 0; i < fill; i++)
						send_item(random_entry(i));
					if (fill < TABLE_DEPTH && $urandom_range(1) == 1) begin
						e = random_entry(fill);
						e.entry_valid = 1'b0;
						send_item(e);
					end
					repeat ($urandom_range(1, 4))
						send_item(random_query());
				end
			endcase
		end
	endtask

	task automatic test_output_stall();
		send_gap_pct = 0;
		rsp_idle_pct = 0;
		stall_left = 300;
		for (int i = 0; i < 10; i++)
			send_item(random_entry(i));
		repeat (8)
			send_item(random_query());
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_gap_pct = 12;
		rsp_idle_pct = 51;
		test_empty_table();
		test_schedule_rules();
		test_week_clamp();
		test_random_traffic(12, 51, 310);
		test_output_stall();
		test_random_traffic(51, 12, 310);
		test_random_traffic(0, 0, 310);

		req.valid <= 1'b0;
		while (expected_alarms.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d slot writes and %0d queries in %0d cycles", n_writes, n_queries, cycles);
		$display("%0d queries found an alarm, %0d of them a full week away", n_found, n_week);
		if (errors == 0)
			$display("tb_weekly_alarm_earliest_finder passed");
		else
			$display("tb_weekly_alarm_earliest_finder failed");
		$finish;
	end

endmodule
